/* hw/rtl/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants, types and helper functions of the Playfair stream core.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned LW = 5;

  localparam logic [LW-1:0] LETTER_X = 5'd23;
  localparam logic [LW-1:0] LETTER_J = 5'd9;
  localparam logic [LW-1:0] LETTER_I = 5'd8;
  localparam logic [LW-1:0] ALPHA    = 5'd26;
  localparam logic [LW-1:0] CELLS    = 5'd25;
  localparam logic [2:0]    SIDE     = 3'd5;

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_TEXT  = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  localparam int unsigned  CFG_ADDR_W      = 3;
  localparam logic [0:0]   REG_IDX_DECRYPT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLACE,
    ST_SWEEP,
    ST_RD_A,
    ST_RD_B,
    ST_MAP,
    ST_RD_C1,
    ST_RD_C2,
    ST_EMIT
  } pfc_state_e;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pfc_rc_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       letter_ok;
    logic       pending_valid;
    logic       pending_same;
    logic       sweep_last;
    logic       out_empty;
  } pfc_status_t;

  typedef struct packed {
    logic capture;
    logic set_pending;
    logic clear_pending;
    logic load_pair;
    logic pair_x;
    logic place;
    logic sweep_start;
    logic sweep_step;
    logic clear_key;
    logic pos_rd;
    logic pos_sel_b;
    logic latch_pa;
    logic map;
    logic cell_rd;
    logic cell_sel_c2;
    logic latch_r1;
    logic out_load;
  } pfc_cmd_t;

  function automatic logic [LW-1:0] fold_letter(logic [LW-1:0] v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  // Splits a square position into row and column. Positions of 25 and above
  // are reduced by 25 first.
  function automatic pfc_rc_t pos_split(logic [LW-1:0] p);
    logic [LW-1:0] q;
    pfc_rc_t       r;
    q = (p >= CELLS) ? p - CELLS : p;
    if (q >= 5'd20) begin
      r.row = 3'd4;
      r.col = 3'(q - 5'd20);
    end else if (q >= 5'd15) begin
      r.row = 3'd3;
      r.col = 3'(q - 5'd15);
    end else if (q >= 5'd10) begin
      r.row = 3'd2;
      r.col = 3'(q - 5'd10);
    end else if (q >= 5'd5) begin
      r.row = 3'd1;
      r.col = 3'(q - 5'd5);
    end else begin
      r.row = 3'd0;
      r.col = 3'(q);
    end
    return r;
  endfunction

  // Adds one (encrypt) or four (decrypt) modulo the side of the square.
  function automatic logic [2:0] step_mod(logic [2:0] v, logic dec);
    logic [3:0] s;
    s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
    if (s >= {1'b0, SIDE}) begin
      s = s - {1'b0, SIDE};
    end
    return s[2:0];
  endfunction

  function automatic logic [LW-1:0] cell_index(logic [2:0] row, logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

/* hw/rtl/playfair_cipher_stream_core.sv */
// ----------------------------------------------------------------------------
// playfair_cipher_stream_core
// Streaming Playfair cipher on letter indices with an APB register port.
// ----------------------------------------------------------------------------
// One item is in work at a time. A valid key letter passes through the place
// state, a close-key item through the sweep, which steps one letter of the
// alphabet per cycle. A letter that completes a pair, or an end item with a
// letter pending, steps through RD_A, RD_B, MAP, RD_C1, RD_C2 and EMIT, as
// the position store and the square store each have a single read port and
// are each read twice. The pair is handed to the two-entry output buffer
// once it has drained, so a stalled result side adds its stall time to that
// item. Each pair gives two result transfers, the second with last high.
module playfair_cipher_stream_core import pfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [LW-1:0]         letter_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LW-1:0]         out_letter_o,
  output logic                  last_o
);

  logic        decrypt_mode_q;
  pfc_status_t status;
  pfc_cmd_t    cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_IDX_DECRYPT)) begin
      decrypt_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_DECRYPT) ? {31'b0, decrypt_mode_q} : 32'b0;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .decrypt_mode_i (decrypt_mode_q),
    .mode_i         (mode_i),
    .letter_i       (letter_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_letter_o   (out_letter_o),
    .last_o         (last_o)
  );

endmodule

/* hw/rtl/pfc_ctrl.sv */
// ----------------------------------------------------------------------------
// pfc_ctrl
// Sequencer of the Playfair stream core: accepts items and steps the datapath
// through key placement, the key sweep and the pair lookup.
// ----------------------------------------------------------------------------
module pfc_ctrl import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pfc_status_t status_i,
  output pfc_cmd_t    cmd_o
);

  pfc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.in_mode)
            MODE_KEY: begin
              if (status_i.letter_ok) state_d = ST_PLACE;
            end
            MODE_CLOSE: state_d = ST_SWEEP;
            MODE_TEXT: begin
              if (status_i.letter_ok && status_i.pending_valid) state_d = ST_RD_A;
            end
            MODE_END: begin
              if (status_i.pending_valid) state_d = ST_RD_A;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PLACE: state_d = ST_IDLE;
      ST_SWEEP: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_MAP;
      ST_MAP:   state_d = ST_RD_C1;
      ST_RD_C1: state_d = ST_RD_C2;
      ST_RD_C2: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_empty) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (status_i.in_mode)
            MODE_KEY: ;
            MODE_CLOSE: cmd_o.sweep_start = 1'b1;
            MODE_TEXT: begin
              if (status_i.letter_ok) begin
                if (!status_i.pending_valid) begin
                  cmd_o.set_pending = 1'b1;
                end else begin
                  // A doubled letter pairs with x and stays pending.
                  cmd_o.load_pair = 1'b1;
                  if (status_i.pending_same) begin
                    cmd_o.pair_x = 1'b1;
                  end else begin
                    cmd_o.clear_pending = 1'b1;
                  end
                end
              end
            end
            MODE_END: begin
              if (status_i.pending_valid) begin
                cmd_o.load_pair     = 1'b1;
                cmd_o.pair_x        = 1'b1;
                cmd_o.clear_pending = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PLACE: cmd_o.place = 1'b1;
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.clear_key  = status_i.sweep_last;
      end
      ST_RD_A: cmd_o.pos_rd = 1'b1;
      ST_RD_B: begin
        cmd_o.pos_rd    = 1'b1;
        cmd_o.pos_sel_b = 1'b1;
        cmd_o.latch_pa  = 1'b1;
      end
      ST_MAP:   cmd_o.map = 1'b1;
      ST_RD_C1: cmd_o.cell_rd = 1'b1;
      ST_RD_C2: begin
        cmd_o.cell_rd     = 1'b1;
        cmd_o.cell_sel_c2 = 1'b1;
        cmd_o.latch_r1    = 1'b1;
      end
      ST_EMIT: cmd_o.out_load = status_i.out_empty;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/pfc_datapath.sv */
// ----------------------------------------------------------------------------
// pfc_datapath
// Key square storage, pending text letter, pair mapping and the two-entry
// output buffer of the Playfair stream core.
// ----------------------------------------------------------------------------
module pfc_datapath import pfc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          decrypt_mode_i,
  input  logic [1:0]    mode_i,
  input  logic [LW-1:0] letter_i,
  input  pfc_cmd_t      cmd_i,
  output pfc_status_t   status_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [LW-1:0] out_letter_o,
  output logic          last_o
);

  logic [LW-1:0] pos_mem  [ALPHA];
  logic [LW-1:0] cell_mem [CELLS];

  logic [ALPHA-1:0] used_q;
  logic [LW-1:0]    fill_q;
  logic             pend_valid_q;
  logic [LW-1:0]    pend_letter_q;
  logic [LW-1:0]    sweep_idx_q;
  logic [LW-1:0]    letter_q;
  logic [LW-1:0]    a_q, b_q;
  logic [LW-1:0]    pos_rd_q;
  logic [LW-1:0]    cell_rd_q;
  pfc_rc_t          pa_q;
  logic [LW-1:0]    c1_q, c2_q;
  logic [LW-1:0]    r1_q;
  logic [1:0]       out_cnt_q;
  logic [LW-1:0]    slot0_q, slot1_q;

  logic [LW-1:0] in_fold;
  logic [LW-1:0] place_letter;
  logic          do_place;
  pfc_rc_t       pb;
  logic [LW-1:0] c1_d, c2_d;
  logic          out_take;

  assign in_fold = fold_letter(letter_i);

  assign status_o.in_mode       = mode_i;
  assign status_o.letter_ok     = (letter_i < ALPHA);
  assign status_o.pending_valid = pend_valid_q;
  assign status_o.pending_same  = (pend_letter_q == in_fold);
  assign status_o.sweep_last    = (sweep_idx_q == ALPHA - 5'd1);
  assign status_o.out_empty     = (out_cnt_q == 2'd0);

  // Key letters and the sweep share one placement path.
  assign place_letter = cmd_i.sweep_step ? sweep_idx_q : letter_q;
  assign do_place     = (cmd_i.place || (cmd_i.sweep_step && sweep_idx_q != LETTER_J))
                        && !used_q[place_letter] && (fill_q < CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q        <= '0;
      fill_q        <= '0;
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      sweep_idx_q   <= '0;
    end else begin
      if (cmd_i.sweep_start) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_idx_q <= sweep_idx_q + 5'd1;
      end

      if (cmd_i.set_pending) begin
        pend_letter_q <= in_fold;
        pend_valid_q  <= 1'b1;
      end else if (cmd_i.clear_pending) begin
        pend_valid_q <= 1'b0;
      end

      if (cmd_i.clear_key) begin
        used_q       <= '0;
        fill_q       <= '0;
        pend_valid_q <= 1'b0;
      end else if (do_place) begin
        used_q[place_letter] <= 1'b1;
        fill_q               <= fill_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_place) begin
      pos_mem[place_letter] <= fill_q;
    end
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[cmd_i.pos_sel_b ? b_q : a_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_place) begin
      cell_mem[fill_q] <= place_letter;
    end
    if (cmd_i.cell_rd) begin
      cell_rd_q <= cell_mem[cmd_i.cell_sel_c2 ? c2_q : c1_q];
    end
  end

  // Pair mapping: same row, then same column, then rectangle corners.
  assign pb = pos_split(pos_rd_q);

  always_comb begin
    if (pa_q.row == pb.row) begin
      c1_d = cell_index(pa_q.row, step_mod(pa_q.col, decrypt_mode_i));
      c2_d = cell_index(pb.row, step_mod(pb.col, decrypt_mode_i));
    end else if (pa_q.col == pb.col) begin
      c1_d = cell_index(step_mod(pa_q.row, decrypt_mode_i), pa_q.col);
      c2_d = cell_index(step_mod(pb.row, decrypt_mode_i), pb.col);
    end else begin
      c1_d = cell_index(pa_q.row, pb.col);
      c2_d = cell_index(pb.row, pa_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      letter_q <= in_fold;
    end
    if (cmd_i.load_pair) begin
      a_q <= pend_letter_q;
      b_q <= cmd_i.pair_x ? LETTER_X : in_fold;
    end
    if (cmd_i.latch_pa) begin
      pa_q <= pos_split(pos_rd_q);
    end
    if (cmd_i.map) begin
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
    if (cmd_i.latch_r1) begin
      r1_q <= cell_rd_q;
    end
  end

  // Output buffer: slot0 is presented, slot1 holds the second letter.
  assign out_take = (out_cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (cmd_i.out_load) begin
      out_cnt_q <= 2'd2;
    end else if (out_take) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot0_q <= r1_q;
      slot1_q <= cell_rd_q;
    end else if (out_take) begin
      slot0_q <= slot1_q;
    end
  end

  assign out_valid_o  = (out_cnt_q != 2'd0);
  assign out_letter_o = slot0_q;
  assign last_o       = (out_cnt_q == 2'd1);

endmodule

/* bench/playfair_cipher_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_stream_checker
// Watches the register port and both streams of the Playfair core, keeps its
// own copy of the key square and the pending letter, and compares every
// result transfer with the oldest predicted letter.
// ----------------------------------------------------------------------------
module playfair_cipher_stream_checker import pfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic                  pready_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            mode_i,
  input  logic [LW-1:0]         letter_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [LW-1:0]         out_letter_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    outstanding_o,
  output int                    results_o
);

  localparam logic [CFG_ADDR_W-1:0] DECRYPT_ADDR = CFG_ADDR_W'({REG_IDX_DECRYPT, 2'b00});
  localparam int SQ = SIDE;
  localparam int NL = ALPHA;
  localparam int NC = CELLS;

  typedef struct packed {
    logic [LW-1:0] letter;
    logic          last;
  } cipher_out_t;

  cipher_out_t   cipher_q[$];
  logic [LW-1:0] pos_of [NL];
  logic          marked [NL];
  logic [LW-1:0] square [NC];
  logic [LW-1:0] fill;
  logic          held_v;
  logic [LW-1:0] held_l;
  logic          decrypt;
  int            n_fail;
  int            n_results;

  function automatic logic [LW-1:0] fold_j(logic [LW-1:0] v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  task automatic place_key_letter(input logic [LW-1:0] v);
    if (!marked[v] && fill < CELLS) begin
      pos_of[v]    = fill;
      square[fill] = v;
      marked[v]    = 1'b1;
      fill         = fill + 1'b1;
    end
  endtask

  task automatic expect_pair(input logic [LW-1:0] a, input logic [LW-1:0] b);
    int sh, pa, pb, ra, ca, rb, cb, c1, c2;
    sh = decrypt ? SQ - 1 : 1;
    pa = int'(pos_of[a]) % NC;
    pb = int'(pos_of[b]) % NC;
    ra = pa / SQ;
    ca = pa % SQ;
    rb = pb / SQ;
    cb = pb % SQ;
    // A letter paired with itself lands in the row case, as the rows match.
    if (ra == rb) begin
      c1 = ra * SQ + (ca + sh) % SQ;
      c2 = rb * SQ + (cb + sh) % SQ;
    end else if (ca == cb) begin
      c1 = ((ra + sh) % SQ) * SQ + ca;
      c2 = ((rb + sh) % SQ) * SQ + cb;
    end else begin
      c1 = ra * SQ + cb;
      c2 = rb * SQ + ca;
    end
    cipher_q.push_back('{letter: square[c1], last: 1'b0});
    cipher_q.push_back('{letter: square[c2], last: 1'b1});
  endtask

  task automatic predict_item(input logic [1:0] m, input logic [LW-1:0] v);
    logic [LW-1:0] f;
    f = fold_j(v);
    case (m)
      MODE_KEY: begin
        if (v < ALPHA) place_key_letter(f);
      end
      MODE_CLOSE: begin
        for (int k = 0; k < NL; k++) begin
          if (k != int'(LETTER_J)) place_key_letter(LW'(k));
        end
        for (int k = 0; k < NL; k++) marked[k] = 1'b0;
        fill   = '0;
        held_v = 1'b0;
      end
      MODE_TEXT: begin
        if (v < ALPHA) begin
          if (!held_v) begin
            held_l = f;
            held_v = 1'b1;
          end else if (held_l == f) begin
            // The second of a doubled letter stays held to open the next pair.
            expect_pair(held_l, LETTER_X);
          end else begin
            expect_pair(held_l, f);
            held_v = 1'b0;
          end
        end
      end
      default: begin
        if (held_v) expect_pair(held_l, LETTER_X);
        held_v = 1'b0;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t want;
    if (!rst_ni) begin
      cipher_q.delete();
      for (int k = 0; k < NL; k++) begin
        pos_of[k] = '0;
        marked[k] = 1'b0;
      end
      for (int k = 0; k < NC; k++) square[k] = '0;
      fill      = '0;
      held_v    = 1'b0;
      held_l    = '0;
      decrypt   = 1'b0;
      n_fail    = 0;
      n_results = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        n_results++;
        if (cipher_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: unexpected letter %0d last %0b", $realtime, out_letter_i, last_i);
          end
        end else begin
          want = cipher_q.pop_front();
          if (want.letter != out_letter_i || want.last != last_i) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: letter %0d last %0b, wanted letter %0d last %0b", $realtime,
                       out_letter_i, last_i, want.letter, want.last);
            end
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == DECRYPT_ADDR) begin
        decrypt = pwdata_i[0];
      end
      if (in_valid_i && !in_stall_i) predict_item(mode_i, letter_i);
    end
    fail_count_o  = n_fail;
    outstanding_o = cipher_q.size();
    results_o     = n_results;
  end

endmodule

/* bench/playfair_cipher_stream_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_stream_core_tb
// Drives keys, text and end markers into the Playfair core under random
// idling on both streams, switches between encryption and decryption while
// the core is idle, and gives the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module playfair_cipher_stream_core_tb import pfc_pkg::*;;

  localparam logic [CFG_ADDR_W-1:0] DECRYPT_ADDR = CFG_ADDR_W'({REG_IDX_DECRYPT, 2'b00});
  localparam int IDLE_PCT    = 24;
  localparam int PHASE_ITEMS = 320;
  localparam int SETTLE      = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            mode_i;
  logic [LW-1:0]         letter_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [LW-1:0]         out_letter_o;
  logic                  last_o;

  int fail_count;
  int outstanding;
  int results;
  int n_sent   = 0;
  int n_taken  = 0;
  int n_writes = 0;
  bit calm     = 1'b0;

  playfair_cipher_stream_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .letter_i    (letter_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_letter_o(out_letter_o),
    .last_o      (last_o)
  );

  playfair_cipher_stream_checker i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .letter_i     (letter_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_letter_i (out_letter_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout: the streams stopped moving");
    $display("tb: failure");
    $finish;
  end

  // Mostly ordinary letters, with extra x and j and a few out of range.
  function automatic logic [LW-1:0] pick_letter();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return LW'($urandom_range(26, 31));
    if (roll < 10) return LETTER_X;
    if (roll < 14) return LETTER_J;
    return LW'($urandom_range(0, 25));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input logic [1:0] m, input logic [LW-1:0] l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    letter_i   <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
    if (!((m == MODE_KEY || m == MODE_TEXT) && l >= ALPHA)) n_taken++;
  endtask

  // A close-key item gives no result, so the core may still be sweeping
  // after the last letter has come out.
  task automatic drain_and_rest();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_decrypt(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DECRYPT_ADDR;
    pwdata  <= {31'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
  endtask

  task automatic random_message();
    int            klen;
    int            tlen;
    int            roll;
    logic [LW-1:0] prev;
    logic [LW-1:0] l;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) push_item(2'($urandom), LW'($urandom));
    end
    if ($urandom_range(99) < 30) begin
      klen = ($urandom_range(99) < 15) ? $urandom_range(24, 34) : $urandom_range(1, 12);
      repeat (klen) push_item(MODE_KEY, pick_letter());
      push_item(MODE_CLOSE, LW'($urandom));
    end
    tlen = $urandom_range(1, 16);
    prev = pick_letter();
    for (int k = 0; k < tlen; k++) begin
      l = (k > 0 && $urandom_range(99) < 15) ? prev : pick_letter();
      push_item(MODE_TEXT, l);
      prev = l;
    end
    roll = $urandom_range(99);
    if (roll < 75) begin
      push_item(MODE_END, LW'($urandom));
    end else if (roll < 85) begin
      push_item(MODE_CLOSE, LW'($urandom));
    end
  endtask

  initial begin
    int goal;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    mode_i     = MODE_KEY;
    letter_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_decrypt(1'b0);

    // Key with a repeat, j folded onto i and two letters out of range.
    push_item(MODE_KEY, 5'd12);
    push_item(MODE_KEY, LETTER_J);
    push_item(MODE_KEY, LETTER_I);
    push_item(MODE_KEY, 5'd12);
    push_item(MODE_KEY, 5'd26);
    push_item(MODE_KEY, 5'd31);
    push_item(MODE_KEY, 5'd0);
    push_item(MODE_KEY, 5'd25);
    push_item(MODE_CLOSE, 5'd31);
    push_item(MODE_TEXT, 5'd31);
    push_item(MODE_TEXT, 5'd0);
    push_item(MODE_TEXT, 5'd25);
    // j then i is a doubled letter; then a rectangle and a run of x.
    push_item(MODE_TEXT, LETTER_J);
    push_item(MODE_TEXT, LETTER_I);
    push_item(MODE_TEXT, LETTER_X);
    push_item(MODE_TEXT, LETTER_X);
    push_item(MODE_TEXT, LETTER_X);
    push_item(MODE_TEXT, LETTER_X);
    push_item(MODE_END, 5'd31);
    push_item(MODE_END, 5'd0);
    // Same row, same column, then a held letter dropped by a close.
    push_item(MODE_TEXT, 5'd3);
    push_item(MODE_TEXT, 5'd4);
    push_item(MODE_TEXT, 5'd2);
    push_item(MODE_TEXT, 5'd7);
    push_item(MODE_TEXT, 5'd5);
    push_item(MODE_CLOSE, 5'd0);
    drain_and_rest();

    for (int ph = 0; ph < 6; ph++) begin
      write_decrypt(ph % 2 == 0);
      calm = (ph == 3);
      goal = n_taken + PHASE_ITEMS;
      while (n_taken < goal) random_message();
      drain_and_rest();
    end

    $display("%0d input transfers (%0d not ignored), %0d result transfers checked",
             n_sent, n_taken, results);
    $display("%0d register writes across both cipher directions, %0d failures",
             n_writes, fail_count + outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ctrl.sv
hw/rtl/pfc_datapath.sv
hw/rtl/playfair_cipher_stream_core.sv
bench/playfair_cipher_stream_checker.sv
bench/playfair_cipher_stream_core_tb.sv
